/* hw/rtl/ilrp_pkg.sv */
package ilrp_pkg;

    // Widths of the literal value and of one character.
    localparam int VALUE_W   = 64;
    localparam int MAX_WIDTH = 64;
    localparam int CHAR_W    = 8;
    localparam int VWIDTH_W  = 7;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Register indexes on the configuration port.
    localparam logic REG_VALUE_WIDTH    = 1'b0;
    localparam logic REG_SIGNED_LITERAL = 1'b1;

    localparam logic [VWIDTH_W-1:0] VALUE_WIDTH_RESET = VWIDTH_W'(64);

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LOWER_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UPPER_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LOWER_B    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_UPPER_B    = 8'h42;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE        = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'd32;
    localparam logic [CHAR_W-1:0] HEX_LETTER_BASE = 8'd10;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    // Phase of the prefix scan; the unused code behaves as the body phase.
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_ZERO  = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] mask;
        logic               is_signed;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        radix_t             radix;
        logic [VALUE_W-1:0] acc;
        logic               seen;
    } state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        radix_t             radix_code;
        logic               is_signed;
        logic               empty_body;
    } result_t;

    // Value mask for a programmed width, clamped to 1..MAX_WIDTH.
    function automatic logic [VALUE_W-1:0] width_mask(input logic [VWIDTH_W-1:0] w);
        logic [VWIDTH_W-1:0] eff;
        logic [VWIDTH_W-1:0] shamt;
        eff = w;
        if (eff == '0)
        begin
            eff = VWIDTH_W'(1);
        end
        if (eff > VWIDTH_W'(MAX_WIDTH))
        begin
            eff = VWIDTH_W'(MAX_WIDTH);
        end
        shamt = VWIDTH_W'(VALUE_W) - eff;
        return {VALUE_W{1'b1}} >> shamt;
    endfunction

    // Unchecked digit value of a body character in the given radix.
    function automatic logic [CHAR_W-1:0] digit_of(input logic [CHAR_W-1:0] c,
                                                   input radix_t r);
        logic [CHAR_W-1:0] u;
        logic              is_dec;
        is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
        u = ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ? (c - CASE_OFFSET) : c;
        if (r == RADIX_BIN)
        begin
            return (c == CH_ONE) ? CHAR_W'(1) : '0;
        end
        else if ((r == RADIX_HEX) && !is_dec)
        begin
            return u - CH_UPPER_A + HEX_LETTER_BASE;
        end
        else
        begin
            return c - CH_ZERO;
        end
    endfunction

endpackage

/* hw/rtl/ilrp_ifs.sv */
// Character channel into the parser.
interface ilrp_in_if;
    logic                             valid;
    logic                             ready;
    logic [ilrp_pkg::CHAR_W-1:0]      char_code;
    logic                             is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// Parsed literal channel out of the parser.
interface ilrp_out_if;
    logic                             valid;
    logic                             ready;
    logic [ilrp_pkg::VALUE_W-1:0]     value;
    logic [1:0]                       radix_code;
    logic                             is_signed;
    logic                             empty_body;

    modport source (output valid, output value, output radix_code, output is_signed,
                    output empty_body, input ready);
    modport sink   (input valid, input value, input radix_code, input is_signed,
                    input empty_body, output ready);
endinterface

/* hw/rtl/ilrp_cfg_regs.sv */
module ilrp_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ilrp_pkg::APB_AW-1:0]   paddr,
    input  logic [ilrp_pkg::APB_DW-1:0]   pwdata,
    output logic [ilrp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output ilrp_pkg::cfg_t                cfg
);

    logic [ilrp_pkg::VWIDTH_W-1:0] width_reg;
    logic [ilrp_pkg::VALUE_W-1:0]  mask_reg;
    logic                          signed_reg;
    logic                          wr_en;
    logic                          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register writes; the value mask is kept precomputed next to the width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ilrp_pkg::VALUE_WIDTH_RESET;
            mask_reg   <= ilrp_pkg::width_mask(ilrp_pkg::VALUE_WIDTH_RESET);
            signed_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                ilrp_pkg::REG_VALUE_WIDTH:
                begin
                    width_reg <= pwdata[ilrp_pkg::VWIDTH_W-1:0];
                    mask_reg  <= ilrp_pkg::width_mask(pwdata[ilrp_pkg::VWIDTH_W-1:0]);
                end
                ilrp_pkg::REG_SIGNED_LITERAL:
                begin
                    signed_reg <= pwdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (reg_sel)
            ilrp_pkg::REG_VALUE_WIDTH:
                prdata = ilrp_pkg::APB_DW'(width_reg);
            ilrp_pkg::REG_SIGNED_LITERAL:
                prdata = ilrp_pkg::APB_DW'(signed_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.mask      = mask_reg;
    assign cfg.is_signed = signed_reg;

endmodule

/* hw/rtl/ilrp_step.sv */
module ilrp_step (
    input  ilrp_pkg::state_t              state,
    input  ilrp_pkg::cfg_t                cfg,
    input  logic [ilrp_pkg::CHAR_W-1:0]   char_code,
    input  logic                          is_last,
    output ilrp_pkg::state_t              state_next,
    output ilrp_pkg::result_t             result
);

    ilrp_pkg::radix_t              rsel;
    ilrp_pkg::phase_t              phase_n;
    logic                          take;
    logic                          zero_last;
    logic                          use_digit;
    logic [ilrp_pkg::VALUE_W-1:0]  shifted;
    logic [ilrp_pkg::VALUE_W-1:0]  acc_n;
    logic                          seen_n;
    logic [ilrp_pkg::CHAR_W-1:0]   digit;

    // Prefix decode: picks the radix and decides whether the character is a body digit.
    always_comb
    begin
        rsel      = state.radix;
        phase_n   = state.phase;
        take      = 1'b0;
        zero_last = 1'b0;
        unique case (state.phase)
            ilrp_pkg::PH_FIRST:
            begin
                if (char_code == ilrp_pkg::CH_ZERO)
                begin
                    rsel = ilrp_pkg::RADIX_OCT;
                    if (is_last)
                    begin
                        zero_last = 1'b1;
                    end
                    else
                    begin
                        phase_n = ilrp_pkg::PH_ZERO;
                    end
                end
                else
                begin
                    rsel    = ilrp_pkg::RADIX_DEC;
                    phase_n = ilrp_pkg::PH_BODY;
                    take    = 1'b1;
                end
            end
            ilrp_pkg::PH_ZERO:
            begin
                phase_n = ilrp_pkg::PH_BODY;
                if ((char_code == ilrp_pkg::CH_LOWER_X) || (char_code == ilrp_pkg::CH_UPPER_X))
                begin
                    rsel = ilrp_pkg::RADIX_HEX;
                end
                else if ((char_code == ilrp_pkg::CH_LOWER_B) ||
                         (char_code == ilrp_pkg::CH_UPPER_B))
                begin
                    rsel = ilrp_pkg::RADIX_BIN;
                end
                else
                begin
                    rsel = ilrp_pkg::RADIX_OCT;
                    take = 1'b1;
                end
            end
            default:
            begin
                take = 1'b1;
            end
        endcase
    end

    assign digit     = ilrp_pkg::digit_of(char_code, rsel);
    assign use_digit = take && (char_code != ilrp_pkg::CH_UNDERSCORE);

    // Scale the accumulator by the radix; times ten is the sum of two shifts.
    always_comb
    begin
        case (rsel)
            ilrp_pkg::RADIX_BIN: shifted = state.acc << 1;
            ilrp_pkg::RADIX_OCT: shifted = state.acc << 3;
            ilrp_pkg::RADIX_HEX: shifted = state.acc << 4;
            default:             shifted = (state.acc << 3) + (state.acc << 1);
        endcase
    end

    // Accumulate the digit and track whether any body digit arrived.
    always_comb
    begin
        acc_n  = state.acc;
        seen_n = state.seen;
        if (zero_last)
        begin
            acc_n  = '0;
            seen_n = 1'b1;
        end
        else if (use_digit)
        begin
            acc_n  = (shifted + ilrp_pkg::VALUE_W'(digit)) & cfg.mask;
            seen_n = 1'b1;
        end
    end

    // The last character emits the result and returns the scanner to its start.
    always_comb
    begin
        result.value      = seen_n ? (acc_n & cfg.mask) : '0;
        result.radix_code = rsel;
        result.is_signed  = cfg.is_signed;
        result.empty_body = !seen_n;
        if (is_last)
        begin
            state_next.phase = ilrp_pkg::PH_FIRST;
            state_next.radix = ilrp_pkg::RADIX_BIN;
            state_next.acc   = '0;
            state_next.seen  = 1'b0;
        end
        else
        begin
            state_next.phase = phase_n;
            state_next.radix = rsel;
            state_next.acc   = acc_n;
            state_next.seen  = seen_n;
        end
    end

endmodule

/* hw/rtl/integer_literal_radix_parser.sv */
// Integer literal parser with radix prefixes.
// The in_ch channel takes one character word per cycle, with is_last on the
// final character of a literal. The prefix selects the radix: 0x/0X hex,
// 0b/0B binary, other leading 0 octal, anything else decimal. Underscores are
// skipped. The out_ch channel gives one word per literal, on its last character.
// Configuration registers sit on an APB port: value_width at address 0 and
// signed_literal at address 4; write them only while the parser is idle.
// Throughput is one character per cycle while in_ch.ready is high. A character
// is registered at the input, then the combinational prefix decode and the
// shift or times-ten accumulate update the scan state, and the result of a
// literal passes from the input register into the output register, where it
// is offered on out_ch. While a result waits in the output register, the
// parser keeps taking characters of the next literal; only the next last
// character stalls in the input register, and in_ch.ready drops then.
// Reset clears the scan state, the pipeline valid flags, value_width to 64
// and signed_literal to 0.
module integer_literal_radix_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    ilrp_in_if.sink                       in_ch,
    ilrp_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ilrp_pkg::APB_AW-1:0]   paddr,
    input  logic [ilrp_pkg::APB_DW-1:0]   pwdata,
    output logic [ilrp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    ilrp_pkg::cfg_t                cfg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [ilrp_pkg::CHAR_W-1:0]   s1_char_reg;
    logic                          s1_last_reg;
    logic                          s1_fire;
    logic                          in_fire;
    ilrp_pkg::state_t              state_reg;
    ilrp_pkg::state_t              state_next;
    ilrp_pkg::result_t             result;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    ilrp_pkg::result_t             out_reg;

    ilrp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ilrp_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .char_code  (s1_char_reg),
        .is_last    (s1_last_reg),
        .state_next (state_next),
        .result     (result)
    );

    // A non-last character never needs the output register, so it always advances.
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Input register and pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_char_reg <= in_ch.char_code;
            s1_last_reg <= in_ch.is_last;
        end
    end

    // Scan state of the literal in progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase <= ilrp_pkg::PH_FIRST;
            state_reg.radix <= ilrp_pkg::RADIX_BIN;
            state_reg.acc   <= '0;
            state_reg.seen  <= 1'b0;
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.value      = out_reg.value;
    assign out_ch.radix_code = out_reg.radix_code;
    assign out_ch.is_signed  = out_reg.is_signed;
    assign out_ch.empty_body = out_reg.empty_body;

endmodule

/* hw/rtl/ilrp_checker.sv */
module ilrp_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [ilrp_pkg::VALUE_W-1:0]  out_value,
    input  logic [1:0]                    out_radix_code,
    input  logic                          out_empty_body
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value, radix code and empty flag.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_radix_code)
            && $stable(out_empty_body))
        else $error("result word changed while stalled");

    // A literal with no body digits reads as zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_empty_body |-> out_value == '0)
        else $error("empty literal with nonzero value");

    // The input stalls only behind a result word the receiver is holding back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // Reset leaves no result on offer.
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind integer_literal_radix_parser ilrp_checker u_ilrp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_value      (out_ch.value),
    .out_radix_code (out_ch.radix_code),
    .out_empty_body (out_ch.empty_body)
);

/* verif/tb_integer_literal_radix_parser.sv */
`timescale 1ns / 100ps

module tb_integer_literal_radix_parser;
    import ilrp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // Byte addresses of the two format registers.
    localparam logic [APB_AW-1:0] ADDR_VALUE_WIDTH    = {REG_VALUE_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SIGNED_LITERAL = {REG_SIGNED_LITERAL, 2'b00};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ilrp_in_if  char_ch();
    ilrp_out_if lit_ch();

    integer_literal_radix_parser u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (char_ch),
        .out_ch  (lit_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Format registers as the parser should hold them.
    logic [VWIDTH_W-1:0] fmt_width;
    logic                fmt_signed;

    // Scan state of the literal in progress.
    phase_t              lit_phase;
    radix_t              lit_radix;
    logic [VALUE_W-1:0]  lit_acc;
    logic                lit_seen;

    // Parsed literal words still owed by the parser, oldest first.
    result_t             pending_literals[$];

    int send_idle_pct;
    int recv_idle_pct;
    int chars_sent;
    int literals_checked;
    int settings_used;
    int error_count;
    int cycle_count;

    // Value mask for a programmed width; zero acts as one, oversize as the maximum.
    function automatic logic [VALUE_W-1:0] value_mask_for(input logic [VWIDTH_W-1:0] w);
        int bits;
        bits = int'(w);
        if (bits < 1)
        begin
            bits = 1;
        end
        if (bits > MAX_WIDTH)
        begin
            bits = MAX_WIDTH;
        end
        if (bits >= VALUE_W)
        begin
            return {VALUE_W{1'b1}};
        end
        return (VALUE_W'(1) << bits) - VALUE_W'(1);
    endfunction

    // Digit value of a body character; nothing is checked against the radix.
    function automatic logic [VALUE_W-1:0] digit_weight(input logic [CHAR_W-1:0] c,
                                                        input radix_t r);
        int code;
        code = int'(c);
        if (r == RADIX_BIN)
        begin
            return (c == CH_ONE) ? VALUE_W'(1) : VALUE_W'(0);
        end
        if ((r == RADIX_HEX) && !((c >= CH_ZERO) && (c <= CH_NINE)))
        begin
            if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z))
            begin
                code = code - int'(CASE_OFFSET);
            end
            return VALUE_W'((code - int'(CH_UPPER_A) + int'(HEX_LETTER_BASE)) & 8'hFF);
        end
        return VALUE_W'((code - int'(CH_ZERO)) & 8'hFF);
    endfunction

    // Fold one body character into the accumulator; underscores are skipped.
    function automatic void absorb_body(input logic [CHAR_W-1:0] c);
        logic [VALUE_W-1:0] d;
        if (c == CH_UNDERSCORE)
        begin
            return;
        end
        d = digit_weight(c, lit_radix);
        case (lit_radix)
            RADIX_BIN: lit_acc = lit_acc << 1;
            RADIX_OCT: lit_acc = lit_acc << 3;
            RADIX_HEX: lit_acc = lit_acc << 4;
            default:   lit_acc = lit_acc * 64'd10;
        endcase
        lit_acc  = (lit_acc + d) & value_mask_for(fmt_width);
        lit_seen = 1'b1;
    endfunction

    // Advance the scan by one accepted character; the last one owes a word.
    function automatic void scan_char(input logic [CHAR_W-1:0] c, input logic last);
        result_t word;
        if (lit_phase == PH_FIRST)
        begin
            if (c == CH_ZERO)
            begin
                lit_radix = RADIX_OCT;
                if (last)
                begin
                    // A lone zero is an octal zero with a digit.
                    lit_acc  = '0;
                    lit_seen = 1'b1;
                end
                else
                begin
                    lit_phase = PH_ZERO;
                end
            end
            else
            begin
                lit_radix = RADIX_DEC;
                lit_phase = PH_BODY;
                absorb_body(c);
            end
        end
        else if (lit_phase == PH_ZERO)
        begin
            lit_phase = PH_BODY;
            if ((c == CH_LOWER_X) || (c == CH_UPPER_X))
            begin
                lit_radix = RADIX_HEX;
            end
            else if ((c == CH_LOWER_B) || (c == CH_UPPER_B))
            begin
                lit_radix = RADIX_BIN;
            end
            else
            begin
                lit_radix = RADIX_OCT;
                absorb_body(c);
            end
        end
        else
        begin
            absorb_body(c);
        end

        if (last)
        begin
            word.value      = lit_seen ? (lit_acc & value_mask_for(fmt_width)) : '0;
            word.radix_code = lit_radix;
            word.is_signed  = fmt_signed;
            word.empty_body = !lit_seen;
            pending_literals.push_back(word);
            lit_phase = PH_FIRST;
            lit_radix = RADIX_BIN;
            lit_acc   = '0;
            lit_seen  = 1'b0;
        end
    endfunction

    // Compare one parsed literal word with the oldest one owed.
    function automatic void match_literal();
        result_t want;
        if (pending_literals.size() == 0)
        begin
            $error("literal word with none owed: value %0h radix %0d",
                   lit_ch.value, lit_ch.radix_code);
            error_count++;
            return;
        end
        want = pending_literals.pop_front();
        literals_checked++;
        if (lit_ch.value !== want.value)
        begin
            $error("value: expected %0h, got %0h", want.value, lit_ch.value);
            error_count++;
        end
        if (lit_ch.radix_code !== want.radix_code)
        begin
            $error("radix_code: expected %0d, got %0d", want.radix_code, lit_ch.radix_code);
            error_count++;
        end
        if (lit_ch.is_signed !== want.is_signed)
        begin
            $error("is_signed: expected %0d, got %0d", want.is_signed, lit_ch.is_signed);
            error_count++;
        end
        if (lit_ch.empty_body !== want.empty_body)
        begin
            $error("empty_body: expected %0d, got %0d", want.empty_body, lit_ch.empty_body);
            error_count++;
        end
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Both channels are watched at the rising edge; words out are checked
    // before the character accepted at the same edge is scanned.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (lit_ch.valid && lit_ch.ready)
            begin
                match_literal();
            end
            if (char_ch.valid && char_ch.ready)
            begin
                scan_char(char_ch.char_code, char_ch.is_last);
            end
        end
    end

    // The receiver stalls at random.
    always @(negedge clk)
    begin
        lit_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one character, with random idle cycles ahead of it.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            char_ch.valid <= 1'b0;
        end
        @(negedge clk);
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.is_last   <= last;
        @(posedge clk);
        while (!char_ch.ready)
        begin
            @(posedge clk);
        end
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // Stop sending and wait until every owed word has come out.
    task automatic wait_idle();
        @(negedge clk);
        char_ch.valid <= 1'b0;
        while (pending_literals.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (addr == ADDR_VALUE_WIDTH)
        begin
            fmt_width = data[VWIDTH_W-1:0];
        end
        else if (addr == ADDR_SIGNED_LITERAL)
        begin
            fmt_signed = data[0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Program both format registers while the parser is idle. The upper data
    // bits are random, since only the low bits belong to the registers.
    task automatic set_format(input int width, input logic is_signed);
        logic [APB_DW-1:0] data;
        wait_idle();
        data = $urandom;
        data[VWIDTH_W-1:0] = VWIDTH_W'(width);
        write_reg(ADDR_VALUE_WIDTH, data);
        data = $urandom;
        data[0] = is_signed;
        write_reg(ADDR_SIGNED_LITERAL, data);
        settings_used++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_from(input string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // One random literal: mostly well formed with random digits, some with
    // stray characters, some underscores only, some raw byte noise.
    task automatic send_literal();
        logic [CHAR_W-1:0] text[$];
        int kind;
        int body_len;
        string digits;
        kind = $urandom_range(99);
        digits = "";
        if (kind < 20)
        begin
            text.push_back(pick_from("123456789"));
            body_len = $urandom_range(22);
            digits = "0123456789";
        end
        else if (kind < 40)
        begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
            body_len = $urandom_range(18);
            digits = "0123456789abcdefABCDEF";
        end
        else if (kind < 55)
        begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(1) ? CH_LOWER_B : CH_UPPER_B);
            body_len = ($urandom_range(3) == 0) ? $urandom_range(70) : $urandom_range(12);
            digits = "01";
        end
        else if (kind < 70)
        begin
            text.push_back(CH_ZERO);
            body_len = $urandom_range(24);
            digits = "01234567";
        end
        else if (kind < 78)
        begin
            // Underscores only.
            text.push_back(CH_UNDERSCORE);
            body_len = $urandom_range(3);
            digits = "_";
        end
        else if (kind < 90)
        begin
            // A first character followed by random printable characters.
            text.push_back(pick_from("0123456789gz_"));
            body_len = $urandom_range(1, 12);
            for (int i = 0; i < body_len; i++)
            begin
                text.push_back(CHAR_W'($urandom_range(8'h20, 8'h7E)));
            end
            body_len = 0;
        end
        else
        begin
            body_len = $urandom_range(1, 10);
            for (int i = 0; i < body_len; i++)
            begin
                text.push_back(CHAR_W'($urandom_range(255)));
            end
            body_len = 0;
        end

        for (int i = 0; i < body_len; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                text.push_back(CH_UNDERSCORE);
            end
            text.push_back(pick_from(digits));
        end

        foreach (text[i])
        begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    task automatic send_random(input int n_chars);
        int target;
        target = chars_sent + n_chars;
        while (chars_sent < target)
        begin
            send_literal();
        end
    endtask

    // Each prefix form, the lone underscore body, and the byte extremes.
    task automatic test_prefix_forms();
        send_idle_pct = 16;
        recv_idle_pct = 73;
        send_text("0");
        send_text("0x");
        send_text("0X");
        send_text("0b");
        send_text("0B");
        send_text("_");
        send_text("0_7");
        send_text("9");
        send_text("0xfF");
        send_text("0b1z");
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    // Narrowest and out-of-range widths, under a slow receiver.
    task automatic test_width_extremes();
        send_idle_pct = 16;
        recv_idle_pct = 73;
        set_format(1, 1'b0);
        send_random(350);
        set_format(0, 1'b1);
        send_random(150);
        set_format(127, 1'b1);
        send_random(250);
    endtask

    // Mid widths and both signedness settings, under a slow sender.
    task automatic test_mid_widths();
        send_idle_pct = 73;
        recv_idle_pct = 16;
        set_format(8, 1'b1);
        send_random(300);
        set_format(33, 1'b0);
        send_random(300);
    endtask

    // Back-to-back words at full width with one full drain in between, then at a random width.
    task automatic test_back_to_back();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_format(64, 1'b0);
        send_random(150);
        wait_idle();
        send_random(150);
        set_format($urandom_range(2, 63), 1'($urandom_range(1)));
        send_random(250);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        char_ch.is_last   = 1'b0;
        lit_ch.ready      = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        chars_sent        = 0;
        literals_checked  = 0;
        settings_used     = 0;
        error_count       = 0;
        cycle_count       = 0;
        fmt_width         = VALUE_WIDTH_RESET;
        fmt_signed        = 1'b0;
        lit_phase         = PH_FIRST;
        lit_radix         = RADIX_BIN;
        lit_acc           = '0;
        lit_seen          = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_prefix_forms();
        test_width_extremes();
        test_mid_widths();
        test_back_to_back();
        wait_idle();

        $display("Sent %0d characters and checked %0d literal words over %0d formats,",
                 chars_sent, literals_checked, settings_used + 1);
        $display("with all prefix forms, underscores, stray bytes and stalls on both sides.");
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ilrp_pkg.sv
hw/rtl/ilrp_ifs.sv
hw/rtl/ilrp_cfg_regs.sv
hw/rtl/ilrp_step.sv
hw/rtl/integer_literal_radix_parser.sv
hw/rtl/ilrp_checker.sv
verif/tb_integer_literal_radix_parser.sv
